/* rtl/core/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// hpt_pkg: shared definitions for the homogeneous point transform
// Operation codes and the per-item control struct.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_DIR   = 2'd2;

    // Per-item control carried alongside the datapath pipeline.
    typedef struct packed {
        logic vld;
        logic point;
    } t_ctl;

endpackage

/* rtl/core/homogeneous_point_transform.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_transform: 4x4 fixed-point point and direction transform
// Four row lanes, three pipelined dividers and a merging output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (valid/ready) carry an operation. A load writes one matrix
//   element and gives no result; operation 3 is dropped. A point item is
//   multiplied by the full matrix and divided by the resulting w; a direction
//   item uses the upper 3x3 part and bypasses the divide.
//   The datapath is one pipeline: the row lanes (product and sum registers),
//   the dividers (an input register, one quotient bit per stage, and an
//   output register) and the output register. Throughput is one item per
//   cycle while the output register is not stalled.
//   The whole pipeline advances only when the output register is empty or
//   being taken, so a stalled receiver freezes it and o_ready drops; no item
//   is lost. A load is applied at acceptance, so a later transform sees it.
//   Reset restores the identity matrix and empties the pipeline.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [3:0]                  i_element_index,
    input  logic signed [WORD_BITS-1:0] i_element_value,
    input  logic signed [WORD_BITS-1:0] i_x_coord,
    input  logic signed [WORD_BITS-1:0] i_y_coord,
    input  logic signed [WORD_BITS-1:0] i_z_coord,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_out_x,
    output logic signed [WORD_BITS-1:0] o_out_y,
    output logic signed [WORD_BITS-1:0] o_out_z,
    output logic                        o_saturated,
    output logic                        o_zero_w
);
    localparam int DIV_LAT = WORD_BITS + FRAC_BITS + 2;
    localparam int LAT     = DIV_LAT + 2;   // lane (2) + divider stages

    logic signed [WORD_BITS-1:0] r_m [0:15];
    logic adv, acc;

    // The output register frees whenever it is empty or being taken.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign acc     = i_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++)
                r_m[k] <= (k % 5 == 0) ? WORD_BITS'(1) << FRAC_BITS : '0;
        end else if (acc && i_operation == hpt_pkg::OP_LOAD) begin
            r_m[i_element_index] <= i_element_value;
        end
    end

    // Lanes: one per matrix row.
    logic signed [WORD_BITS-1:0] row_val [0:3];
    logic                        row_clip [0:3];
    logic is_point;
    assign is_point = i_operation == hpt_pkg::OP_POINT;

    for (genvar r = 0; r < 4; r++) begin : g_lane
        hpt_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_m0   (r_m[4*r]),
            .i_m1   (r_m[4*r+1]),
            .i_m2   (r_m[4*r+2]),
            .i_m3   (r_m[4*r+3]),
            .i_x    (i_x_coord),
            .i_y    (i_y_coord),
            .i_z    (i_z_coord),
            .i_point(is_point),
            .o_val  (row_val[r]),
            .o_clip (row_clip[r])
        );
    end

    // Control pipeline runs in step with the datapath.
    hpt_pkg::t_ctl r_ctl [0:LAT];
    always_comb begin
        r_ctl[0].vld   = acc && (i_operation == hpt_pkg::OP_POINT ||
                                 i_operation == hpt_pkg::OP_DIR);
        r_ctl[0].point = is_point;
    end
    for (genvar s = 1; s <= LAT; s++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_ctl[s] <= '0;
            else if (adv)  r_ctl[s] <= r_ctl[s-1];
        end
    end

    // Row results at lane output carry along the divider delay.
    logic signed [WORD_BITS-1:0] r_dx [0:DIV_LAT][0:2];
    logic r_clip_d [0:DIV_LAT];
    logic r_wz_d   [0:DIV_LAT];
    always_comb begin
        for (int j = 0; j < 3; j++) r_dx[0][j] = row_val[j];
        r_clip_d[0] = row_clip[0] | row_clip[1] | row_clip[2] |
                      (r_ctl[2].point & row_clip[3]);
        r_wz_d[0]   = row_val[3] == '0;
    end
    for (genvar s = 1; s <= DIV_LAT; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dx[s]     <= r_dx[s-1];
                r_clip_d[s] <= r_clip_d[s-1];
                r_wz_d[s]   <= r_wz_d[s-1];
            end
        end
    end

    logic signed [WORD_BITS-1:0] quo [0:2];
    logic                        qclip [0:2];
    for (genvar j = 0; j < 3; j++) begin : g_div
        hpt_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (row_val[j]),
            .i_den (row_val[3]),
            .o_quo (quo[j]),
            .o_clip(qclip[j])
        );
    end

    // Merge: choose direction result, divided point, or zero-w result.
    logic pt, wz;
    assign pt = r_ctl[LAT].point;
    assign wz = r_wz_d[DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_ctl[LAT].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_zero_w <= pt && wz;
            if (!pt) begin
                o_out_x     <= r_dx[DIV_LAT][0];
                o_out_y     <= r_dx[DIV_LAT][1];
                o_out_z     <= r_dx[DIV_LAT][2];
                o_saturated <= r_clip_d[DIV_LAT];
            end else if (wz) begin
                o_out_x     <= '0;
                o_out_y     <= '0;
                o_out_z     <= '0;
                o_saturated <= r_clip_d[DIV_LAT];
            end else begin
                o_out_x     <= quo[0];
                o_out_y     <= quo[1];
                o_out_z     <= quo[2];
                o_saturated <= r_clip_d[DIV_LAT] | qclip[0] | qclip[1] | qclip[2];
            end
        end
    end

    // A stalled result must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_zero_w))
        else $error("result changed while stalled");
    // Zero w only ever goes with zero outputs.
    a_zw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_w |-> o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
        else $error("zero w with nonzero output");
    // Ready is withheld only while a result waits.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("ready dropped without a stall");
endmodule

/* rtl/core/hpt_lane.sv */
// ----------------------------------------------------------------------------
// hpt_lane: one matrix row times the input vector
// Four registered products, then sum, shift and saturation into a registered result.
// ----------------------------------------------------------------------------
module hpt_lane #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_m0,
    input  logic signed [WORD_BITS-1:0] i_m1,
    input  logic signed [WORD_BITS-1:0] i_m2,
    input  logic signed [WORD_BITS-1:0] i_m3,
    input  logic signed [WORD_BITS-1:0] i_x,
    input  logic signed [WORD_BITS-1:0] i_y,
    input  logic signed [WORD_BITS-1:0] i_z,
    input  logic                        i_point,
    output logic signed [WORD_BITS-1:0] o_val,
    output logic                        o_clip
);
    localparam int PW = 2 * WORD_BITS;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;
    logic signed [SW-1:0] lim_hi, lim_lo;
    logic signed [WORD_BITS-1:0] n_val;
    logic                        n_clip;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= PW'(i_m0) * PW'(i_x);
            r_p1 <= PW'(i_m1) * PW'(i_y);
            r_p2 <= PW'(i_m2) * PW'(i_z);
            r_p3 <= i_point ? (PW'(i_m3) <<< FRAC_BITS) : '0;
        end
    end

    always_comb begin
        sum     = SW'(r_p0) + SW'(r_p1) + SW'(r_p2) + SW'(r_p3);
        shifted = sum >>> FRAC_BITS;
        lim_hi  = SW'({1'b0, {(WORD_BITS-1){1'b1}}});
        lim_lo  = -lim_hi - SW'(1);
        n_clip  = 1'b0;
        if (shifted > lim_hi) begin
            n_val  = {1'b0, {(WORD_BITS-1){1'b1}}};
            n_clip = 1'b1;
        end else if (shifted < lim_lo) begin
            n_val  = {1'b1, {(WORD_BITS-1){1'b0}}};
            n_clip = 1'b1;
        end else begin
            n_val = shifted[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_val  <= n_val;
            o_clip <= n_clip;
        end
    end
endmodule

/* rtl/core/hpt_div.sv */
// ----------------------------------------------------------------------------
// hpt_div: pipelined restoring divider with saturation
// Computes (n * 2^FRAC_BITS) / d truncated toward zero, one quotient bit per
// stage, then clips to the signed word range.
// ----------------------------------------------------------------------------
module hpt_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_num,
    input  logic signed [WORD_BITS-1:0] i_den,
    output logic signed [WORD_BITS-1:0] o_quo,
    output logic                        o_clip
);
    localparam int NW = WORD_BITS + FRAC_BITS;   // numerator and quotient width
    localparam int RW = WORD_BITS + 1;           // remainder width

    logic [NW-1:0] r_num [0:NW];
    logic [NW-1:0] r_quo [0:NW];
    logic [RW-1:0] r_rem [0:NW];
    logic [WORD_BITS-1:0] r_den [0:NW];
    logic r_neg [0:NW];

    logic [WORD_BITS-1:0] mag_n, mag_d;
    assign mag_n = i_num[WORD_BITS-1] ? WORD_BITS'(-i_num) : i_num;
    assign mag_d = i_den[WORD_BITS-1] ? WORD_BITS'(-i_den) : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= {mag_n, {FRAC_BITS{1'b0}}};
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_den[0] <= mag_d;
            r_neg[0] <= i_num[WORD_BITS-1] ^ i_den[WORD_BITS-1];
        end
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [RW-1:0] trial;
        logic          ge;
        assign trial = {r_rem[s][RW-2:0], r_num[s][NW-1]};
        assign ge    = trial >= RW'(r_den[s]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= r_num[s] << 1;
                r_rem[s+1] <= ge ? trial - RW'(r_den[s]) : trial;
                r_quo[s+1] <= {r_quo[s][NW-2:0], ge};
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    logic [NW-1:0] q;
    logic          big;
    assign q   = r_quo[NW];
    assign big = r_neg[NW] ? (q > NW'({1'b1, {(WORD_BITS-1){1'b0}}}))
                           : (q > NW'({1'b0, {(WORD_BITS-1){1'b1}}}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_clip <= big;
            if (big) o_quo <= r_neg[NW] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                        : {1'b0, {(WORD_BITS-1){1'b1}}};
            else     o_quo <= r_neg[NW] ? WORD_BITS'(-q[WORD_BITS-1:0])
                                        : q[WORD_BITS-1:0];
        end
    end
endmodule
